// ===== rtl/core/interference_aware_host_picker_macros.svh =====
// ----------------------------------------------------------------------------
// Interference-aware host picker: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INTERFERENCE_AWARE_HOST_PICKER_MACROS_SVH
`define INTERFERENCE_AWARE_HOST_PICKER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define IAHP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define IAHP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/iahp_pkg.sv =====
// ----------------------------------------------------------------------------
// Interference-aware host picker: package
// Record types, command and state codes, and the interference penalty table.
// ----------------------------------------------------------------------------
package iahp_pkg;

  // Interference factor is unsigned Q1.16; this is 1.0.
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef enum logic [1:0] {
    CMD_HOST  = 2'd0,
    CMD_SLOT  = 2'd1,
    CMD_PLACE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HOST,
    ST_SLOT,
    ST_SCORE,
    ST_CMP,
    ST_DONE
  } state_t;

  // One host record as held in the host table.
  typedef struct packed {
    logic [15:0] ram;
    logic [15:0] disk;
    logic [15:0] net;
    logic [7:0]  cpus;
    logic [23:0] speed;
  } host_rec_t;

  // One task slot as held in the slot table.
  typedef struct packed {
    logic       busy;
    logic [1:0] kind;
  } slot_rec_t;

  // Kind three is treated as kind two.
  function automatic logic [1:0] clamp_kind(input logic [1:0] k);
    clamp_kind = (k == 2'd3) ? 2'd2 : k;
  endfunction

  // Penalty in Q0.16 for a request kind running beside a slot kind.
  function automatic logic [15:0] penalty(input logic [1:0] rk, input logic [1:0] sk);
    logic [3:0] sel;
    sel = {clamp_kind(rk), clamp_kind(sk)};
    case (sel)
      4'b00_00: penalty = 16'd61604;
      4'b00_01: penalty = 16'd62915;
      4'b00_10: penalty = 16'd59638;
      4'b01_00: penalty = 16'd60293;
      4'b01_01: penalty = 16'd55050;
      4'b01_10: penalty = 16'd55706;
      4'b10_00: penalty = 16'd51773;
      4'b10_01: penalty = 16'd50463;
      default:  penalty = 16'd42598;
    endcase
  endfunction

endpackage

// ===== rtl/core/iahp_store.sv =====
// ----------------------------------------------------------------------------
// Interference-aware host picker: host and slot tables
// Two single-port-write memories with registered reads, cleared by a sweep
// of one slot entry per cycle after reset.
// ----------------------------------------------------------------------------
module iahp_store
  import iahp_pkg::*;
#(
  parameter int NUM_HOSTS = 16,
  parameter int MAX_TASKS = 8,
  localparam int SLOTS = NUM_HOSTS * MAX_TASKS,
  localparam int HAW = (NUM_HOSTS > 1) ? $clog2(NUM_HOSTS) : 1,
  localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int SPW = $clog2(SLOTS + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           host_we,
  input  logic [HAW-1:0] host_waddr,
  input  host_rec_t      host_wdata,
  input  logic           host_re,
  input  logic [HAW-1:0] host_raddr,
  output host_rec_t      host_rdata,
  input  logic           slot_we,
  input  logic [SAW-1:0] slot_waddr,
  input  slot_rec_t      slot_wdata,
  input  logic           slot_re,
  input  logic [SAW-1:0] slot_raddr,
  output slot_rec_t      slot_rdata,
  output logic           clearing
);

  host_rec_t      host_mem [NUM_HOSTS];
  slot_rec_t      slot_mem [SLOTS];
  logic [SPW-1:0] sweep;

  // Clearing sweep runs once after reset over every slot entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep    <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      if (sweep == SPW'(SLOTS - 1)) begin
        clearing <= 1'b0;
      end
      sweep <= sweep + SPW'(1);
    end
  end

  // Host table write port; the sweep zeroes it alongside the slot table.
  always_ff @(posedge clk) begin
    if (clearing) begin
      if (sweep < SPW'(NUM_HOSTS)) begin
        host_mem[HAW'(sweep)] <= '0;
      end
    end else if (host_we) begin
      host_mem[host_waddr] <= host_wdata;
    end
  end

  // Slot table write port.
  always_ff @(posedge clk) begin
    if (clearing) begin
      slot_mem[sweep[SAW-1:0]] <= '0;
    end else if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
  end

  // Registered reads; data holds until the next read.
  always_ff @(posedge clk) begin
    if (host_re) begin
      host_rdata <= host_mem[host_raddr];
    end
    if (slot_re) begin
      slot_rdata <= slot_mem[slot_raddr];
    end
  end

endmodule

// ===== rtl/core/interference_aware_host_picker.sv =====
// ----------------------------------------------------------------------------
// Interference-aware host picker
// Keeps host resources and task slots, and on a placement request scores each
// host that fits as interference factor times speed, picking the first best.
// ----------------------------------------------------------------------------
//  channel | signals                      | direction | carries
//  in      | in_valid, in_stall, fields   | into      | table writes and requests
//  out     | out_valid, out_stall, fields | out of    | one result per request
//
// Table writes (cmd 0 and 1) are taken in idle. A request walks the hosts in order;
// a host that lacks a resource is skipped, and one that fits has each of its
// slots walked and is then scored and compared. The single shared multiplier is
// used once per slot and once for the score.
// After reset the tables are swept clear, with in_stall high. A finished result
// waits in the output register while the next item is taken; a second result
// waits until the first one has left.
// ----------------------------------------------------------------------------
`include "interference_aware_host_picker_macros.svh"

module interference_aware_host_picker
  import iahp_pkg::*;
#(
  parameter int NUM_HOSTS = 16,
  parameter int MAX_TASKS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [3:0]  host_index,
  input  logic [2:0]  slot_index,
  input  logic        slot_busy,
  input  logic [1:0]  kind,
  input  logic [15:0] ram_amount,
  input  logic [15:0] disk_amount,
  input  logic [15:0] net_amount,
  input  logic [7:0]  cpu_amount,
  input  logic [23:0] speed_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [3:0]  chosen_host,
  output logic [39:0] best_score
);

  localparam int SLOTS = NUM_HOSTS * MAX_TASKS;
  localparam int HAW = (NUM_HOSTS > 1) ? $clog2(NUM_HOSTS) : 1;
  localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SPW = $clog2(SLOTS + 1);
  localparam int SCW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  state_t         state, state_next;
  logic [HAW-1:0] host_ptr;
  logic [SCW-1:0] slot_cnt;
  logic [SPW-1:0] slot_ptr;
  logic [16:0]    factor;
  logic [39:0]    score_q;
  logic [39:0]    best;
  logic [HAW-1:0] best_host;
  logic           hit;
  logic [15:0]    req_ram;
  logic [15:0]    req_disk;
  logic [15:0]    req_net;
  logic [7:0]     req_cpu;
  logic [1:0]     req_kind;

  logic           accept;
  logic           host_ok;
  logic           slot_ok;
  logic           fits;
  logic           host_last;
  logic           slot_last;
  logic           out_free;
  logic           better;
  logic [23:0]    mul_b;
  logic [40:0]    product;

  logic           host_we;
  logic           host_re;
  logic [HAW-1:0] host_raddr;
  host_rec_t      host_wdata;
  host_rec_t      host_rdata;
  logic           slot_we;
  logic           slot_re;
  logic [SAW-1:0] slot_waddr;
  slot_rec_t      slot_wdata;
  slot_rec_t      slot_rdata;
  logic           clearing;

  iahp_store #(
    .NUM_HOSTS(NUM_HOSTS),
    .MAX_TASKS(MAX_TASKS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .host_we    (host_we),
    .host_waddr (HAW'(host_index)),
    .host_wdata (host_wdata),
    .host_re    (host_re),
    .host_raddr (host_raddr),
    .host_rdata (host_rdata),
    .slot_we    (slot_we),
    .slot_waddr (slot_waddr),
    .slot_wdata (slot_wdata),
    .slot_re    (slot_re),
    .slot_raddr (slot_ptr[SAW-1:0]),
    .slot_rdata (slot_rdata),
    .clearing   (clearing)
  );

  // Handshake and address decode for table writes.
  assign in_stall   = clearing || (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign host_ok    = 32'(host_index) < NUM_HOSTS;
  assign slot_ok    = 32'(slot_index) < MAX_TASKS;
  assign slot_waddr = SAW'(32'(host_index) * MAX_TASKS + 32'(slot_index));
  assign host_wdata = '{ram: ram_amount, disk: disk_amount, net: net_amount,
                        cpus: cpu_amount, speed: speed_value};
  assign slot_wdata = '{busy: slot_busy, kind: kind};

  // Scan status for the host and slot under work.
  assign fits = (host_rdata.ram >= req_ram) && (host_rdata.disk >= req_disk) &&
                (host_rdata.net >= req_net) && (host_rdata.cpus >= req_cpu);
  assign host_last = (host_ptr == HAW'(NUM_HOSTS - 1));
  assign slot_last = (slot_cnt == SCW'(MAX_TASKS - 1));
  assign better    = score_q > best;

  // Shared multiplier: penalty steps during the slot walk, speed for the score.
  assign mul_b   = (state == ST_SCORE) ? host_rdata.speed
                                       : {8'd0, penalty(req_kind, slot_rdata.kind)};
  assign product = 41'(factor) * 41'(mul_b);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and table port control.
  always_comb begin
    state_next = state;
    host_we    = 1'b0;
    slot_we    = 1'b0;
    host_re    = 1'b0;
    slot_re    = 1'b0;
    host_raddr = host_ptr + HAW'(1);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_HOST:  host_we = host_ok;
            CMD_SLOT:  slot_we = host_ok && slot_ok;
            CMD_PLACE: begin
              host_re    = 1'b1;
              host_raddr = '0;
              state_next = ST_HOST;
            end
            default: ;
          endcase
        end
      end
      ST_HOST: begin
        if (fits) begin
          slot_re    = 1'b1;
          state_next = ST_SLOT;
        end else if (host_last) begin
          state_next = ST_DONE;
        end else begin
          host_re = 1'b1;
        end
      end
      ST_SLOT: begin
        if (slot_last) begin
          state_next = ST_SCORE;
        end else begin
          slot_re = 1'b1;
        end
      end
      ST_SCORE: state_next = ST_CMP;
      ST_CMP: begin
        if (host_last) begin
          state_next = ST_DONE;
        end else begin
          host_re    = 1'b1;
          state_next = ST_HOST;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Request datapath: pointers, factor, running best.
  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= ONE_Q16;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (cmd == CMD_PLACE)) begin
            req_ram   <= ram_amount;
            req_disk  <= disk_amount;
            req_net   <= net_amount;
            req_cpu   <= cpu_amount;
            req_kind  <= clamp_kind(kind);
            host_ptr  <= '0;
            slot_ptr  <= '0;
            best      <= '0;
            best_host <= '0;
            hit       <= 1'b0;
          end
        end
        ST_HOST: begin
          factor   <= ONE_Q16;
          slot_cnt <= '0;
          if (fits) begin
            slot_ptr <= slot_ptr + SPW'(1);
          end else begin
            slot_ptr <= slot_ptr + SPW'(MAX_TASKS);
            if (!host_last) begin
              host_ptr <= host_ptr + HAW'(1);
            end
          end
        end
        ST_SLOT: begin
          if (slot_rdata.busy) begin
            factor <= product[32:16];
          end
          slot_cnt <= slot_cnt + SCW'(1);
          if (!slot_last) begin
            slot_ptr <= slot_ptr + SPW'(1);
          end
        end
        ST_SCORE: score_q <= product[39:0];
        ST_CMP: begin
          if (better) begin
            best      <= score_q;
            best_host <= host_ptr;
            hit       <= 1'b1;
          end
          if (!host_last) begin
            host_ptr <= host_ptr + HAW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Output register holds one result item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      found       <= hit;
      chosen_host <= 4'(best_host);
      best_score  <= best;
    end
  end

  // The factor only ever shrinks from 1.0.
  `IAHP_ASSERT_ALWAYS(a_factor_max, factor <= ONE_Q16, "interference factor above 1.0")
  // No item is taken while the tables are being cleared.
  `IAHP_ASSERT_IMP(a_clear_stall, clearing, in_stall, "item accepted during clearing")
  // A not-found result carries zero index and zero score.
  `IAHP_ASSERT_IMP(a_miss_zero, out_valid && !found, (~|{chosen_host, best_score}), "miss data")

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Host picker regression bench
// Drives table writes and placement requests through the valid/stall input
// channel, keeps a shadow copy of the host and slot tables, and scores every
// placement request itself. Each result leaving the block is checked field by
// field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top
  import iahp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_HOSTS = 16;
  localparam int MAX_TASKS = 8;
  localparam int RANDOM_ITEMS = 700;
  localparam int TAIL_CYCLES = 200;

  // One item on the input channel, with the idle gap the sender waits before it.
  typedef struct packed {
    cmd_t        op;
    logic [3:0]  host;
    logic [2:0]  slot;
    logic        busy;
    logic [1:0]  kind;
    logic [15:0] ram;
    logic [15:0] disk;
    logic [15:0] net;
    logic [7:0]  cpu;
    logic [23:0] speed;
    logic [3:0]  gap;
    logic        drain;
  } job_t;

  // One placement decision.
  typedef struct packed {
    logic        found;
    logic [3:0]  host;
    logic [39:0] score;
  } placement_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = CMD_HOST;
  logic [3:0]  host_index = '0;
  logic [2:0]  slot_index = '0;
  logic        slot_busy = 1'b0;
  logic [1:0]  kind = '0;
  logic [15:0] ram_amount = '0;
  logic [15:0] disk_amount = '0;
  logic [15:0] net_amount = '0;
  logic [7:0]  cpu_amount = '0;
  logic [23:0] speed_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found;
  logic [3:0]  chosen_host;
  logic [39:0] best_score;

  // Shadow tables of the block.
  logic [15:0] ram_tab   [NUM_HOSTS];
  logic [15:0] disk_tab  [NUM_HOSTS];
  logic [15:0] net_tab   [NUM_HOSTS];
  logic [7:0]  cpu_tab   [NUM_HOSTS];
  logic [23:0] speed_tab [NUM_HOSTS];
  logic        busy_tab  [NUM_HOSTS * MAX_TASKS];
  logic [1:0]  kind_tab  [NUM_HOSTS * MAX_TASKS];

  job_t       pending[$];
  placement_t placements_due[$];
  job_t       next_job;
  job_t       on_bus;
  logic       staged = 1'b0;
  int         gap_left = 0;
  int         hold_left = 0;
  int         results_seen = 0;
  int         errors = 0;

  interference_aware_host_picker u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .host_index  (host_index),
    .slot_index  (slot_index),
    .slot_busy   (slot_busy),
    .kind        (kind),
    .ram_amount  (ram_amount),
    .disk_amount (disk_amount),
    .net_amount  (net_amount),
    .cpu_amount  (cpu_amount),
    .speed_value (speed_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .chosen_host (chosen_host),
    .best_score  (best_score)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Kind three behaves as kind two.
  function automatic logic [1:0] fold_kind(input logic [1:0] k);
    fold_kind = (k == 2'd3) ? 2'd2 : k;
  endfunction

  // Slowdown in Q0.16 of a request kind sharing a host with a busy slot kind.
  function automatic logic [15:0] slowdown_q16(input logic [1:0] rk, input logic [1:0] sk);
    case ({rk, sk})
      4'b00_00: slowdown_q16 = 16'd61604;
      4'b00_01: slowdown_q16 = 16'd62915;
      4'b00_10: slowdown_q16 = 16'd59638;
      4'b01_00: slowdown_q16 = 16'd60293;
      4'b01_01: slowdown_q16 = 16'd55050;
      4'b01_10: slowdown_q16 = 16'd55706;
      4'b10_00: slowdown_q16 = 16'd51773;
      4'b10_01: slowdown_q16 = 16'd50463;
      default:  slowdown_q16 = 16'd42598;
    endcase
  endfunction

  // Applies one accepted item to the shadow tables; a request queues its placement.
  function automatic void predict_item(input job_t j);
    logic [16:0] factor;
    logic [32:0] prod;
    logic [40:0] score;
    logic [40:0] top;
    logic [3:0]  top_host;
    logic        hit;
    logic [1:0]  rk;
    int          idx;
    placement_t  p;
    case (j.op)
      CMD_HOST: begin
        ram_tab[j.host]   = j.ram;
        disk_tab[j.host]  = j.disk;
        net_tab[j.host]   = j.net;
        cpu_tab[j.host]   = j.cpu;
        speed_tab[j.host] = j.speed;
      end
      CMD_SLOT: begin
        idx = j.host * MAX_TASKS + j.slot;
        busy_tab[idx] = j.busy;
        kind_tab[idx] = j.kind;
      end
      CMD_PLACE: begin
        rk = fold_kind(j.kind);
        top = '0;
        top_host = '0;
        hit = 1'b0;
        for (int h = 0; h < NUM_HOSTS; h++) begin
          if (ram_tab[h] >= j.ram && disk_tab[h] >= j.disk &&
              net_tab[h] >= j.net && cpu_tab[h] >= j.cpu) begin
            factor = ONE_Q16;
            for (int s = 0; s < MAX_TASKS; s++) begin
              idx = h * MAX_TASKS + s;
              if (busy_tab[idx]) begin
                prod = factor * slowdown_q16(rk, fold_kind(kind_tab[idx]));
                factor = prod[32:16];
              end
            end
            score = factor * speed_tab[h];
            // Only a strictly higher score replaces an earlier host.
            if (score > top) begin
              top = score;
              top_host = 4'(h);
              hit = 1'b1;
            end
          end
        end
        p.found = hit;
        p.host = hit ? top_host : 4'd0;
        p.score = hit ? top[39:0] : 40'd0;
        placements_due.push_back(p);
      end
      default: begin
      end
    endcase
  endfunction

  // An item with every field random; callers overwrite what they care about.
  function automatic job_t scramble();
    job_t j;
    j.op    = cmd_t'(2'($urandom_range(0, 3)));
    j.host  = 4'($urandom);
    j.slot  = 3'($urandom);
    j.busy  = 1'($urandom);
    j.kind  = 2'($urandom);
    j.ram   = 16'($urandom);
    j.disk  = 16'($urandom);
    j.net   = 16'($urandom);
    j.cpu   = 8'($urandom);
    j.speed = 24'($urandom);
    // Some stretches of the run go without any sender idling.
    j.gap   = ((pending.size() % 160) < 30) ? 4'd0 : 4'($urandom_range(0, 9));
    j.drain = 1'b0;
    return j;
  endfunction

  task automatic add_host(input int h, input int r, input int d, input int n, input int c,
                          input int spd);
    job_t j;
    j = scramble();
    j.op = CMD_HOST;
    j.host = 4'(h);
    j.ram = 16'(r);
    j.disk = 16'(d);
    j.net = 16'(n);
    j.cpu = 8'(c);
    j.speed = 24'(spd);
    pending.push_back(j);
  endtask

  task automatic add_slot(input int h, input int s, input bit b, input int k);
    job_t j;
    j = scramble();
    j.op = CMD_SLOT;
    j.host = 4'(h);
    j.slot = 3'(s);
    j.busy = b;
    j.kind = 2'(k);
    pending.push_back(j);
  endtask

  task automatic add_place(input int k, input int r, input int d, input int n, input int c,
                           input bit drain);
    job_t j;
    j = scramble();
    j.op = CMD_PLACE;
    j.kind = 2'(k);
    j.ram = 16'(r);
    j.disk = 16'(d);
    j.net = 16'(n);
    j.cpu = 8'(c);
    j.drain = drain;
    pending.push_back(j);
  endtask

  // Draws a host capacity, mostly comfortable, sometimes anything or the maximum.
  function automatic int capacity(input int full);
    int m;
    m = $urandom_range(0, 19);
    if (m < 14) return $urandom_range(full / 6, full);
    if (m < 17) return $urandom_range(0, full);
    return full;
  endfunction

  // Draws a requested amount; zero and small requests keep most hosts eligible.
  function automatic int demand(input int full, input int mode);
    if (mode < 6) return $urandom_range(0, full / 3);
    if (mode < 8) return 0;
    if (mode < 9) return $urandom_range(0, full);
    return full;
  endfunction

  // Stimulus: a directed opening, then a random mix of writes and requests.
  initial begin
    job_t j;
    int   op;
    int   mode;
    int   spd;

    // Empty tables: every host fits a zero request but scores zero.
    add_place(0, 0, 0, 0, 0, 1'b0);
    add_host(0, 65535, 65535, 65535, 255, 24'hFFFFFF);
    add_host(15, 65535, 65535, 65535, 255, 24'hFFFFFF);
    // Equal scores on hosts 0 and 15: the lower index keeps the win.
    add_place(0, 0, 0, 0, 0, 1'b0);
    add_slot(0, 0, 1'b1, 0);
    add_slot(0, 7, 1'b1, 3);
    add_place(3, 65535, 65535, 65535, 255, 1'b0);
    // A free slot still records its kind.
    add_slot(15, 3, 1'b0, 2);
    add_place(1, 65535, 65535, 65535, 255, 1'b0);
    for (int s = 0; s < MAX_TASKS; s++) add_slot(15, s, 1'b1, s % 4);
    add_place(2, 1, 1, 1, 1, 1'b0);
    add_host(7, 1, 1, 1, 1, 1);
    add_place(0, 2, 0, 0, 0, 1'b0);
    // The unused command is ignored.
    j = scramble();
    j.op = CMD_NONE;
    pending.push_back(j);
    add_host(0, 65535, 65535, 65535, 255, 0);
    add_place(1, 65535, 65535, 65535, 255, 1'b0);
    add_host(15, 0, 0, 0, 0, 24'hFFFFFF);
    add_place(0, 1, 0, 0, 0, 1'b0);

    // Random part; two requests wait until the block has delivered everything.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      op = $urandom_range(0, 19);
      // The draining requests always go out as requests.
      if (n == 0 || n == RANDOM_ITEMS / 2) op = 12;
      if (op < 5) begin
        mode = $urandom_range(0, 9);
        spd = (mode == 0) ? 0 : (mode == 1) ? 24'hFFFFFF : $urandom_range(0, 24'hFFFFFF);
        add_host($urandom_range(0, NUM_HOSTS - 1), capacity(65535), capacity(65535),
                 capacity(65535), capacity(255), spd);
      end else if (op < 12) begin
        add_slot($urandom_range(0, NUM_HOSTS - 1), $urandom_range(0, MAX_TASKS - 1),
                 $urandom_range(0, 9) < 7, $urandom_range(0, 3));
      end else if (op < 19 || n == 0 || n == RANDOM_ITEMS / 2) begin
        mode = $urandom_range(0, 9);
        add_place($urandom_range(0, 3), demand(65535, mode), demand(65535, mode),
                  demand(65535, mode), demand(255, mode),
                  n == 0 || n == RANDOM_ITEMS / 2);
      end else begin
        j = scramble();
        j.op = CMD_NONE;
        pending.push_back(j);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Drain, then leave room for any stray result.
    while (pending.size() != 0 || staged || in_valid || placements_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("interference_aware_host_picker regression: pass");
    end else begin
      $display("interference_aware_host_picker regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung block.
  initial begin
    #6000000;
    $display("interference_aware_host_picker regression: fail");
    $finish;
  end

  // Reset contents of the shadow tables.
  initial begin
    for (int h = 0; h < NUM_HOSTS; h++) begin
      ram_tab[h] = '0;
      disk_tab[h] = '0;
      net_tab[h] = '0;
      cpu_tab[h] = '0;
      speed_tab[h] = '0;
    end
    for (int i = 0; i < NUM_HOSTS * MAX_TASKS; i++) begin
      busy_tab[i] = 1'b0;
      kind_tab[i] = '0;
    end
  end

  // Sender: waits out each item's gap, holds it until accepted, predicts on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_item(on_bus);
      end
      if (!in_valid || !in_stall) begin
        if (!staged && pending.size() != 0) begin
          next_job = pending.pop_front();
          staged = 1'b1;
          gap_left = next_job.gap;
        end
        if (staged && gap_left == 0 && (!next_job.drain || placements_due.size() == 0)) begin
          on_bus = next_job;
          staged = 1'b0;
          in_valid <= 1'b1;
          cmd <= next_job.op;
          host_index <= next_job.host;
          slot_index <= next_job.slot;
          slot_busy <= next_job.busy;
          kind <= next_job.kind;
          ram_amount <= next_job.ram;
          disk_amount <= next_job.disk;
          net_amount <= next_job.net;
          cpu_amount <= next_job.cpu;
          speed_value <= next_job.speed;
        end else begin
          in_valid <= 1'b0;
          if (staged && gap_left != 0) gap_left = gap_left - 1;
        end
      end
    end
  end

  // Receiver: checks each accepted result, then stalls for a drawn number of cycles.
  always @(posedge clk) begin
    placement_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen = results_seen + 1;
        if (placements_due.size() == 0) begin
          $error("unexpected result: found %0d chosen_host %0d best_score %0d",
                 found, chosen_host, best_score);
          errors = errors + 1;
        end else begin
          want = placements_due.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found);
            errors = errors + 1;
          end
          if (chosen_host !== want.host) begin
            $error("chosen_host: expected %0d, actual %0d", want.host, chosen_host);
            errors = errors + 1;
          end
          if (best_score !== want.score) begin
            $error("best_score: expected %0d, actual %0d", want.score, best_score);
            errors = errors + 1;
          end
        end
        // Long hold-offs let the block fill up and stall its input.
        if (results_seen == 40 || results_seen == 250) begin
          hold_left = 600;
        end else if ((results_seen % 150) < 30) begin
          hold_left = 0;
        end else begin
          hold_left = $urandom_range(0, 9);
        end
      end else if (hold_left != 0) begin
        hold_left = hold_left - 1;
      end
      out_stall <= (hold_left != 0);
    end
  end

endmodule
